### rtl/sqh_pkg.sv
// Shared constants and helper functions for the approximate binary32 square root.
// Used by sqh_fmul, sqh_fadd and float32_sqrt_householder; no dependencies.
`default_nettype none

package sqh_pkg;

   localparam logic [31:0] MAGIC_GUESS = 32'h5f1110a0;
   localparam logic [31:0] K_ONE       = 32'h401214c9;   // 2.2825186
   localparam logic [31:0] K_TWO       = 32'h40103626;   // 2.2533049
   localparam logic [31:0] FP_ONE      = 32'h3f800000;
   localparam logic [31:0] FP_HALF     = 32'h3f000000;
   localparam logic [31:0] CANON_NAN   = 32'h7fc00000;
   localparam logic [7:0]  EXP_MAX     = 8'hff;
   localparam int          PIPE_DEPTH  = 34;             // valid line length

   // leading zero count, 48 bits wide (48 when the word is zero)
   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            n = 6'(47 - i);
         end
      end
      return n;
   endfunction

   // leading zero count, 28 bits wide (28 when the word is zero)
   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] n;
      n = 5'd28;
      for (int i = 0; i < 28; i++) begin
         if (v[i]) begin
            n = 5'(27 - i);
         end
      end
      return n;
   endfunction

   // round to nearest even and pack; exp is the biased field (0 = subnormal frame)
   function automatic logic [31:0] round_pack(input logic       sign,
                                               input logic [9:0] exp,
                                               input logic [23:0] mant,
                                               input logic       guard,
                                               input logic       sticky);
      logic        up;
      logic [24:0] m25;
      logic [9:0]  ef;
      logic [22:0] frac;
      up   = guard & (sticky | mant[0]);
      m25  = {1'b0, mant} + {24'd0, up};
      ef   = exp + {9'd0, m25[24]} + {9'd0, (exp == 10'd0) & m25[23]};
      frac = m25[24] ? m25[23:1] : m25[22:0];
      if (ef >= 10'd255) begin
         return {sign, EXP_MAX, 23'd0};
      end
      return {sign, ef[7:0], frac};
   endfunction

endpackage

`default_nettype wire

### rtl/sqh_fmul.sv
// Three-stage binary32 multiplier, round to nearest even, subnormals kept.
// Depends on sqh_pkg (lzc48, round_pack, constants).
`default_nettype none

module sqh_fmul (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic [31:0]      q
);
   import sqh_pkg::*;

   // stage 1: multiply
   logic               s1_sign_ff, s1_nan_ff, s1_inf_ff, s1_zero_ff;
   logic [47:0]        s1_prod_ff;
   logic signed [10:0] s1_exp_ff;
   // stage 2: normalize
   logic               s2_sign_ff, s2_nan_ff, s2_inf_ff, s2_zero_ff, s2_stk_ff;
   logic [47:0]        s2_norm_ff;
   logic [9:0]         s2_exp_ff;
   // stage 3: round
   logic [31:0]        res_ff;

   logic [7:0]  ea, eb, ea_eff, eb_eff;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [23:0] ma, mb;

   always_comb begin
      ea     = a[30:23];
      eb     = b[30:23];
      ea_eff = (ea == 8'd0) ? 8'd1 : ea;
      eb_eff = (eb == 8'd0) ? 8'd1 : eb;
      ma     = {ea != 8'd0, a[22:0]};
      mb     = {eb != 8'd0, b[22:0]};
      a_nan  = (ea == EXP_MAX) && (a[22:0] != 23'd0);
      b_nan  = (eb == EXP_MAX) && (b[22:0] != 23'd0);
      a_inf  = (ea == EXP_MAX) && (a[22:0] == 23'd0);
      b_inf  = (eb == EXP_MAX) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sign_ff <= a[31] ^ b[31];
         s1_prod_ff <= ma * mb;
         s1_exp_ff  <= $signed({3'd0, ea_eff}) + $signed({3'd0, eb_eff}) - 11'sd127;
         s1_nan_ff  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
         s1_inf_ff  <= a_inf | b_inf;
         s1_zero_ff <= a_zero | b_zero;
      end
   end

   logic [5:0]         lz;
   logic signed [10:0] rs;
   logic [95:0]        wide;
   logic [47:0]        norm;
   logic               stk;
   logic [9:0]         nexp;
   logic signed [10:0] exp_n;

   always_comb begin
      lz    = lzc48(s1_prod_ff);
      rs    = -s1_exp_ff;
      exp_n = s1_exp_ff + 11'sd1 - $signed({5'd0, lz});
      wide  = {s1_prod_ff, 48'd0} >> rs[5:0];
      norm  = '0;
      stk   = 1'b0;
      nexp  = 10'd0;
      if (s1_exp_ff < 11'sd0) begin
         if (rs >= 11'sd48) begin
            stk = |s1_prod_ff;
         end else begin
            norm = wide[95:48];
            stk  = |wide[47:0];
         end
      end else if ($signed({5'd0, lz}) <= s1_exp_ff) begin
         norm = s1_prod_ff << lz;
         nexp = exp_n[9:0];
      end else begin
         norm = s1_prod_ff << s1_exp_ff[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sign_ff <= s1_sign_ff;
         s2_nan_ff  <= s1_nan_ff;
         s2_inf_ff  <= s1_inf_ff;
         s2_zero_ff <= s1_zero_ff;
         s2_norm_ff <= norm;
         s2_stk_ff  <= stk;
         s2_exp_ff  <= nexp;
      end
   end

   logic [31:0] res_in;

   always_comb begin
      priority if (s2_nan_ff) begin
         res_in = CANON_NAN;
      end else if (s2_inf_ff) begin
         res_in = {s2_sign_ff, EXP_MAX, 23'd0};
      end else if (s2_zero_ff) begin
         res_in = {s2_sign_ff, 31'd0};
      end else begin
         res_in = round_pack(s2_sign_ff, s2_exp_ff, s2_norm_ff[47:24], s2_norm_ff[23],
                             (|s2_norm_ff[22:0]) | s2_stk_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign q = res_ff;

endmodule

`default_nettype wire

### rtl/sqh_fadd.sv
// Three-stage binary32 adder/subtractor, round to nearest even, subnormals kept.
// Depends on sqh_pkg (lzc28, round_pack, constants).
`default_nettype none

module sqh_fadd (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic        sub,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic [31:0]      q
);
   import sqh_pkg::*;

   // stage 1: swap and align
   logic        s1_sign_ff, s1_eop_ff, s1_nan_ff, s1_inf_ff, s1_isign_ff;
   logic        s1_bz_ff, s1_zsign_ff;
   logic [26:0] s1_big_ff, s1_small_ff;
   logic [7:0]  s1_exp_ff;
   // stage 2: add and count
   logic        s2_sign_ff, s2_nan_ff, s2_inf_ff, s2_isign_ff, s2_bz_ff, s2_zsign_ff;
   logic [27:0] s2_sum_ff;
   logic [4:0]  s2_lz_ff;
   logic [7:0]  s2_exp_ff;
   // stage 3: normalize and round
   logic [31:0] res_ff;

   logic [31:0] bb, big, lesser;
   logic [7:0]  eb_eff, es_eff, d;
   logic [26:0] mb27, ms27, shifted, lost;
   logic        a_nan, b_nan, a_inf, b_inf;

   always_comb begin
      bb      = {b[31] ^ sub, b[30:0]};
      a_nan   = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
      b_nan   = (bb[30:23] == EXP_MAX) && (bb[22:0] != 23'd0);
      a_inf   = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
      b_inf   = (bb[30:23] == EXP_MAX) && (bb[22:0] == 23'd0);
      if (a[30:0] >= bb[30:0]) begin
         big    = a;
         lesser = bb;
      end else begin
         big    = bb;
         lesser = a;
      end
      eb_eff  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es_eff  = (lesser[30:23] == 8'd0) ? 8'd1 : lesser[30:23];
      d       = eb_eff - es_eff;
      mb27    = {big[30:23] != 8'd0, big[22:0], 3'd0};
      ms27    = {lesser[30:23] != 8'd0, lesser[22:0], 3'd0};
      if (d >= 8'd27) begin
         lost    = ms27;
         shifted = {26'd0, |ms27};
      end else begin
         lost    = ms27 & ~({27{1'b1}} << d[4:0]);
         shifted = (ms27 >> d[4:0]) | {26'd0, |lost};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sign_ff  <= big[31];
         s1_eop_ff   <= a[31] ^ bb[31];
         s1_big_ff   <= mb27;
         s1_small_ff <= shifted;
         s1_exp_ff   <= eb_eff;
         s1_nan_ff   <= a_nan | b_nan | (a_inf & b_inf & (a[31] ^ bb[31]));
         s1_inf_ff   <= a_inf | b_inf;
         s1_isign_ff <= a_inf ? a[31] : bb[31];
         s1_bz_ff    <= (a[30:0] == 31'd0) && (bb[30:0] == 31'd0);
         s1_zsign_ff <= a[31] & bb[31];
      end
   end

   logic [27:0] sum;

   always_comb begin
      if (s1_eop_ff) begin
         sum = {1'b0, s1_big_ff} - {1'b0, s1_small_ff};
      end else begin
         sum = {1'b0, s1_big_ff} + {1'b0, s1_small_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sign_ff  <= s1_sign_ff;
         s2_nan_ff   <= s1_nan_ff;
         s2_inf_ff   <= s1_inf_ff;
         s2_isign_ff <= s1_isign_ff;
         s2_bz_ff    <= s1_bz_ff;
         s2_zsign_ff <= s1_zsign_ff;
         s2_sum_ff   <= sum;
         s2_lz_ff    <= lzc28(sum);
         s2_exp_ff   <= s1_exp_ff;
      end
   end

   logic [27:0] norm;
   logic [9:0]  nexp;
   logic [31:0] res_in;

   always_comb begin
      if ({3'd0, s2_lz_ff} <= s2_exp_ff) begin
         norm = s2_sum_ff << s2_lz_ff;
         nexp = {2'd0, s2_exp_ff} + 10'd1 - {5'd0, s2_lz_ff};
      end else begin
         norm = s2_sum_ff << s2_exp_ff[4:0];
         nexp = 10'd0;
      end
      priority if (s2_nan_ff) begin
         res_in = CANON_NAN;
      end else if (s2_inf_ff) begin
         res_in = {s2_isign_ff, EXP_MAX, 23'd0};
      end else if (s2_sum_ff == 28'd0) begin
         // exact cancellation gives +0; two zeros keep their common sign
         res_in = {s2_bz_ff & s2_zsign_ff, 31'd0};
      end else begin
         res_in = round_pack(s2_sign_ff, nexp, norm[27:4], norm[3], |norm[2:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign q = res_ff;

endmodule

`default_nettype wire

### rtl/float32_sqrt_householder.sv
// Approximate binary32 square root: magic-constant guess plus Householder refinement.
// Depends on sqh_pkg, sqh_fmul and sqh_fadd.
//
// Usage:
//   Input channel req_*: req_valid with req_operand_bits; a transaction is taken at a
//   rising edge with req_valid high and req_stall low. Result channel rsp_*: rsp_valid
//   with rsp_root_bits; the receiver holds rsp_stall high to keep it waiting.
//   Every input transaction gives exactly one result transaction, in order.
// Structure: one input register computes the guess, then eleven dependent binary32
//   operations of three stages each (multiply, normalize, round; or align, add,
//   normalize and round) form the critical chain.
// Throughput: one transaction per cycle while no result waits under rsp_stall; every
//   stage is a register stage with a valid bit riding alongside the data.
// Stall: the whole pipeline freezes while a result waits under rsp_stall; req_stall is
//   then high and nothing in flight is lost or repeated. Bubbles advance freely.
// Reset: synchronous, active high; clears the valid line only, the pipe then drains.
// NaN results leave as the canonical quiet NaN 0x7fc00000.
`default_nettype none

module float32_sqrt_householder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_operand_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_root_bits
);
   import sqh_pkg::*;

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // valid line, one bit per pipeline step
   logic [PIPE_DEPTH-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   // input register: operand and first reciprocal-root guess
   logic [31:0] x_s0_ff, y0_s0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x_s0_ff  <= req_operand_bits;
         y0_s0_ff <= MAGIC_GUESS - {1'b0, req_operand_bits[31:1]};
      end
   end

   // unit outputs
   logic [31:0] a_q, c_q, d_q, e_q, f_q, y_q, c2_q, g_q, h_q, t_q, i_q, r_q;

   // delay lines that line operands up with the pipelined units
   logic [31:0] x_dly_ff  [0:17];
   logic [31:0] y0_dly_ff [0:14];
   logic [31:0] c_dly_ff  [0:2];
   logic [31:0] y_dly_ff  [0:2];
   logic [31:0] h_dly_ff  [0:2];
   logic [31:0] c2_dly_ff [0:8];

   always_ff @(posedge clock) begin
      if (en) begin
         x_dly_ff[0]  <= x_s0_ff;
         y0_dly_ff[0] <= y0_s0_ff;
         c_dly_ff[0]  <= c_q;
         y_dly_ff[0]  <= y_q;
         h_dly_ff[0]  <= h_q;
         c2_dly_ff[0] <= c2_q;
         for (int k = 1; k < 18; k++) x_dly_ff[k]  <= x_dly_ff[k-1];
         for (int k = 1; k < 15; k++) y0_dly_ff[k] <= y0_dly_ff[k-1];
         for (int k = 1; k < 3; k++)  c_dly_ff[k]  <= c_dly_ff[k-1];
         for (int k = 1; k < 3; k++)  y_dly_ff[k]  <= y_dly_ff[k-1];
         for (int k = 1; k < 3; k++)  h_dly_ff[k]  <= h_dly_ff[k-1];
         for (int k = 1; k < 9; k++)  c2_dly_ff[k] <= c2_dly_ff[k-1];
      end
   end

   // Householder step on the reciprocal root
   sqh_fmul u_a  (.clock, .en, .a(x_s0_ff),       .b(y0_s0_ff),     .q(a_q));
   sqh_fmul u_c  (.clock, .en, .a(a_q),           .b(y0_dly_ff[2]), .q(c_q));
   sqh_fadd u_d  (.clock, .en, .sub(1'b1), .a(K_TWO), .b(c_q),      .q(d_q));
   sqh_fmul u_e  (.clock, .en, .a(c_dly_ff[2]),   .b(d_q),          .q(e_q));
   sqh_fadd u_f  (.clock, .en, .sub(1'b1), .a(K_ONE), .b(e_q),      .q(f_q));
   sqh_fmul u_y  (.clock, .en, .a(y0_dly_ff[14]), .b(f_q),          .q(y_q));
   // final step to the root
   sqh_fmul u_c2 (.clock, .en, .a(x_dly_ff[17]),  .b(y_q),          .q(c2_q));
   sqh_fmul u_g  (.clock, .en, .a(y_dly_ff[2]),   .b(c2_q),         .q(g_q));
   sqh_fmul u_h  (.clock, .en, .a(FP_HALF),       .b(c2_q),         .q(h_q));
   sqh_fadd u_t  (.clock, .en, .sub(1'b1), .a(FP_ONE), .b(g_q),     .q(t_q));
   sqh_fmul u_i  (.clock, .en, .a(h_dly_ff[2]),   .b(t_q),          .q(i_q));
   sqh_fadd u_r  (.clock, .en, .sub(1'b0), .a(i_q), .b(c2_dly_ff[8]), .q(r_q));

   assign rsp_root_bits = r_q;

`ifndef SYNTHESIS
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(vld_ff))
      else $error("valid line moved while the result was stalled");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_canon: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_root_bits[30:23] == EXP_MAX && rsp_root_bits[22:0] != 23'd0)
      |-> (rsp_root_bits == CANON_NAN))
      else $error("non-canonical NaN on the result channel");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(r_q))
      else $error("final adder output changed while stalled");
`endif

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for float32_sqrt_householder: random and directed operands.
// A scoreboard class predicts each root bit for bit; depends on the RTL top and sqh_pkg.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Expected roots for accepted operands, oldest first.
   // Each binary32 operation runs in double precision and is then rounded once
   // to binary32 (RNE). Add, subtract and multiply come out correctly rounded
   // this way, because a double holds more than twice the binary32 precision.
   class root_scoreboard;
      logic [31:0] root_q[$];
      int          mismatches = 0;
      int          matched    = 0;

      // binary32 bits -> exact double value
      function real widen(logic [31:0] b);
         real r;
         if (b[30:23] == 8'hff) begin
            if (b[22:0] != 0) begin
               return $bitstoreal(64'h7ff8000000000000);
            end
            return $bitstoreal({b[31], 63'h7ff0000000000000});
         end
         if (b[30:23] == 8'h00) begin
            r = $itor(b[22:0]) * (2.0 ** (-149));
         end else begin
            r = $itor({1'b1, b[22:0]}) * (2.0 ** ($signed({24'd0, b[30:23]}) - 150));
         end
         return b[31] ? -r : r;
      endfunction

      // double -> binary32 bits, round to nearest even, subnormals kept
      function logic [31:0] narrow(real r);
         logic [63:0] d, m, kept, low_mask;
         logic        s, guard, sticky;
         int          fe, sh;
         d = $realtobits(r);
         s = d[63];
         if (d[62:52] == 11'h7ff) begin
            if (d[51:0] != 0) begin
               return sqh_pkg::CANON_NAN;
            end
            return {s, 8'hff, 23'd0};
         end
         if (d[62:52] == 11'h000) begin
            return {s, 31'd0};
         end
         m  = {11'd0, 1'b1, d[51:0]};
         fe = $signed({21'd0, d[62:52]}) - 1023 + 127;
         sh = (fe >= 1) ? 29 : 29 + (1 - fe);
         if (sh > 60) begin
            sh = 60;
         end
         kept     = m >> sh;
         guard    = m[sh-1];
         low_mask = (64'd1 << (sh - 1)) - 64'd1;
         sticky   = |(m & low_mask);
         if (guard && (sticky || kept[0])) begin
            kept = kept + 64'd1;
         end
         if (fe >= 1) begin
            if (kept[24]) begin
               kept = kept >> 1;
               fe   = fe + 1;
            end
            if (fe >= 255) begin
               return {s, 8'hff, 23'd0};
            end
            return {s, fe[7:0], kept[22:0]};
         end
         // subnormal frame: a carry into bit 23 becomes the smallest normal
         return {s, 7'd0, kept[23], kept[22:0]};
      endfunction

      function logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
         return narrow(widen(a) * widen(b));
      endfunction

      function logic [31:0] sub32(logic [31:0] a, logic [31:0] b);
         return narrow(widen(a) - widen(b));
      endfunction

      function logic [31:0] add32(logic [31:0] a, logic [31:0] b);
         return narrow(widen(a) + widen(b));
      endfunction

      function logic [31:0] predict_root(logic [31:0] x);
         logic [31:0] y, c, t, r;
         y = sqh_pkg::MAGIC_GUESS - {1'b0, x[31:1]};   // wraps mod 2^32
         c = mul32(mul32(x, y), y);
         y = mul32(y, sub32(sqh_pkg::K_ONE, mul32(c, sub32(sqh_pkg::K_TWO, c))));
         c = mul32(x, y);
         t = sub32(sqh_pkg::FP_ONE, mul32(y, c));
         r = add32(mul32(mul32(sqh_pkg::FP_HALF, c), t), c);
         if (r[30:23] == 8'hff && r[22:0] != 0) begin
            r = sqh_pkg::CANON_NAN;
         end
         return r;
      endfunction

      function void note_operand(logic [31:0] x);
         root_q.push_back(predict_root(x));
      endfunction

      function void check_root(logic [31:0] got);
         logic [31:0] want;
         if (root_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result %h with nothing pending", got);
            end
            return;
         end
         want = root_q.pop_front();
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("root mismatch: expected %h actual %h", want, got);
            end
         end else begin
            matched++;
         end
      endfunction

      function int pending();
         return root_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_operand_bits = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_root_bits;

   root_scoreboard sb = new();
   bit  long_hold_req = 1'b0;   // receiver holds off for a long stretch when set
   int  sent_count = 0;

   float32_sqrt_householder uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operand_bits(req_operand_bits),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_root_bits(rsp_root_bits)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard limit: far beyond the slowest expected run.
   initial begin
      #4ms;
      $display("Mismatches found");
      $finish;
   end

   // Offer one transaction; valid stays high if the caller sends another right away.
   task automatic offer_operand(input logic [31:0] v);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_operand_bits <= v;
      do begin
         @(posedge clock);
      end while (req_stall);
      sb.note_operand(v);
      sent_count++;
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      idle_sender(1);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Operand mix: raw noise, normals spread over the range, near one,
   // subnormals, specials, and negative patterns where the guess may wrap.
   function automatic logic [31:0] pick_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 7))
         0, 1: ;
         2, 3: v = {1'b0, 8'($urandom_range(1, 254)), v[22:0]};
         4:    v = {1'b0, 8'($urandom_range(118, 136)), v[22:0]};
         5:    v = {v[31], 8'h00, v[22:0]};
         6:    v = {v[31], 8'hff, ($urandom_range(0, 1) != 0) ? 23'd0 : v[22:0]};
         default: v = {1'b1, v[30:0]};
      endcase
      return v;
   endfunction

   task automatic random_bursts(input int count);
      int burst;
      int i;
      i = 0;
      while (i < count) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && i < count) begin
            offer_operand(pick_operand());
            burst--;
            i++;
         end
         if ($urandom_range(0, 3) != 0) begin
            idle_sender($urandom_range(0, 9));
         end
      end
   endtask

   // Receiver: stall pattern in stretches of varying density; a long hold on request.
   initial begin
      int stretch;
      int density;
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (150) @(negedge clock);
         end
         stretch = $urandom_range(1, 40);
         density = $urandom_range(0, 3);   // 0: never stall, 3: mostly stalled
         repeat (stretch) begin
            @(negedge clock);
            rsp_stall <= ($urandom_range(0, 3) < density);
         end
      end
   end

   // Result monitor: a transaction is a rising edge with valid high and stall low.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_root(rsp_root_bits);
      end
   end

   initial begin
      logic [31:0] directed[$];
      int leftover;
      int failures;
      int guard_cycles;
      directed = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h007fffff,
                   32'h80000001, 32'h00800000, 32'h3f800000, 32'h40800000,
                   32'h40000000, 32'h3e800000, 32'h7f7fffff, 32'h7f800000,
                   32'hff800000, 32'h7fc00000, 32'h7f800001, 32'hffffffff,
                   32'hbe222140, 32'hbe222142, 32'hc0000000, 32'hbf800000,
                   32'h5f1110a0, 32'h7effffff, 32'h12345678, 32'h3f7fffff};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes and special cases, back to back
      foreach (directed[i]) begin
         offer_operand(directed[i]);
      end
      // sender pause until every result is back
      wait_drained();

      // long receiver hold while operands keep coming: pipe fills, input stalls
      long_hold_req = 1'b1;
      repeat (80) offer_operand(pick_operand());

      random_bursts(150);
      wait_drained();
      random_bursts(170);

      idle_sender(1);
      guard_cycles = 0;
      while (sb.pending() != 0 && guard_cycles < 20000) begin
         @(negedge clock);
         guard_cycles++;
      end
      repeat (2 * sqh_pkg::PIPE_DEPTH) @(negedge clock);

      leftover = sb.pending();
      failures = sb.mismatches + leftover;
      if (leftover != 0) begin
         $display("%0d expected results never arrived", leftover);
      end
      $display("Sent %0d operands (specials, subnormals, wrapped guesses, random);",
               sent_count);
      $display("%0d roots matched, %0d mismatched, with stalls and gaps on both sides.",
               sb.matched, sb.mismatches);
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
